// ----- design/flvtm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FLV tag muxer package
// Shared types and constants for the FLV byte stream serializer.
// ----------------------------------------------------------------------------
package flvtm_pkg;

   localparam logic [1:0] ACT_FILE = 2'd0;
   localparam logic [1:0] ACT_TAG  = 2'd1;
   localparam logic [1:0] ACT_DATA = 2'd2;

   localparam logic [1:0] KIND_AUDIO  = 2'd0;
   localparam logic [1:0] KIND_VIDEO  = 2'd1;
   localparam logic [1:0] KIND_SCRIPT = 2'd2;

   localparam logic [7:0] TYPE_CODE_AUDIO  = 8'd8;
   localparam logic [7:0] TYPE_CODE_VIDEO  = 8'd9;
   localparam logic [7:0] TYPE_CODE_SCRIPT = 8'd18;

   localparam int MAX_JOB_LEN   = 15;
   localparam int IDX_W         = $clog2(MAX_JOB_LEN);
   localparam int FILE_BODY_LEN = 9;
   localparam int TAG_BODY_LEN  = 11;
   localparam int DATA_BODY_LEN = 1;
   localparam int TRAILER_LEN   = 4;
   localparam int TRAILER_W     = 25;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  stream_kind;
      logic [23:0] payload_size;
      logic [31:0] source_time;
      logic [7:0]  data_byte;
   } flvtm_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } flvtm_rsp_type;

   typedef enum logic [1:0] {
      OP_FILE,
      OP_TAG,
      OP_DATA
   } flvtm_op_type;

   typedef struct packed {
      flvtm_op_type           op;
      logic                   trailer_en;
      logic [7:0]             type_code;
      logic [23:0]            size;
      logic [31:0]            stamp;
      logic [7:0]             data;
      logic [TRAILER_W-1:0]   trailer;
   } flvtm_job_type;

endpackage
`default_nettype wire

// ----- design/flvtm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FLV tag muxer front end
// Accepts items, keeps the timestamp and open-tag state, and issues jobs.
// ----------------------------------------------------------------------------
module flvtm_front
   import flvtm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire flvtm_req_type req_payload,
   input  wire logic          q_full,
   output logic               push,
   output flvtm_job_type      push_job
);

   logic                 audio_pend_ff, audio_pend_in;
   logic                 video_pend_ff, video_pend_in;
   logic [31:0]          epoch_ff, epoch_in;
   logic [31:0]          audio_out_ff, audio_out_in;
   logic [31:0]          audio_src_ff, audio_src_in;
   logic [31:0]          video_out_ff, video_out_in;
   logic [31:0]          video_src_ff, video_src_in;
   logic [23:0]          bytes_left_ff, bytes_left_in;
   logic [TRAILER_W-1:0] trailer_ff, trailer_in;

   logic        accept;
   logic [31:0] ts;
   logic [31:0] audio_stamp;
   logic [31:0] video_stamp;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign ts        = req_payload.source_time;

   always_comb begin
      if (audio_pend_ff) begin
         audio_stamp = video_pend_ff ? 32'd0 : ts - epoch_ff;
      end else begin
         audio_stamp = audio_out_ff + (ts - audio_src_ff);
      end
      if (video_pend_ff) begin
         video_stamp = audio_pend_ff ? 32'd0 : ts - epoch_ff;
      end else begin
         video_stamp = video_out_ff + (ts - video_src_ff);
      end
   end

   always_comb begin
      audio_pend_in = audio_pend_ff;
      video_pend_in = video_pend_ff;
      epoch_in      = epoch_ff;
      audio_out_in  = audio_out_ff;
      audio_src_in  = audio_src_ff;
      video_out_in  = video_out_ff;
      video_src_in  = video_src_ff;
      bytes_left_in = bytes_left_ff;
      trailer_in    = trailer_ff;
      push          = 1'b0;
      push_job      = '0;
      if (accept) begin
         case (req_payload.action)
            ACT_FILE: begin
               audio_pend_in       = 1'b1;
               video_pend_in       = 1'b1;
               epoch_in            = '0;
               audio_out_in        = '0;
               audio_src_in        = '0;
               video_out_in        = '0;
               video_src_in        = '0;
               bytes_left_in       = '0;
               trailer_in          = '0;
               push                = 1'b1;
               push_job.op         = OP_FILE;
               push_job.trailer_en = 1'b1;
            end
            ACT_TAG: begin
               if (req_payload.stream_kind inside {KIND_AUDIO, KIND_VIDEO, KIND_SCRIPT}) begin
                  push                = 1'b1;
                  push_job.op         = OP_TAG;
                  push_job.size       = req_payload.payload_size;
                  push_job.trailer    = {1'b0, req_payload.payload_size}
                                        + TRAILER_W'(TAG_BODY_LEN);
                  push_job.trailer_en = (req_payload.payload_size == '0);
                  bytes_left_in       = req_payload.payload_size;
                  trailer_in          = push_job.trailer;
                  case (req_payload.stream_kind)
                     KIND_AUDIO: begin
                        push_job.type_code = TYPE_CODE_AUDIO;
                        push_job.stamp     = audio_stamp;
                        audio_pend_in      = 1'b0;
                        audio_out_in       = audio_stamp;
                        audio_src_in       = ts;
                        if (audio_pend_ff && video_pend_ff) begin
                           epoch_in = ts;
                        end
                     end
                     KIND_VIDEO: begin
                        push_job.type_code = TYPE_CODE_VIDEO;
                        push_job.stamp     = video_stamp;
                        video_pend_in      = 1'b0;
                        video_out_in       = video_stamp;
                        video_src_in       = ts;
                        if (audio_pend_ff && video_pend_ff) begin
                           epoch_in = ts;
                        end
                     end
                     default: begin
                        push_job.type_code = TYPE_CODE_SCRIPT;
                        push_job.stamp     = ts;
                     end
                  endcase
               end
            end
            ACT_DATA: begin
               if (bytes_left_ff != '0) begin
                  push                = 1'b1;
                  push_job.op         = OP_DATA;
                  push_job.data       = req_payload.data_byte;
                  push_job.trailer    = trailer_ff;
                  push_job.trailer_en = (bytes_left_ff == 24'd1);
                  bytes_left_in       = bytes_left_ff - 24'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_pend_ff <= 1'b1;
         video_pend_ff <= 1'b1;
         epoch_ff      <= '0;
         audio_out_ff  <= '0;
         audio_src_ff  <= '0;
         video_out_ff  <= '0;
         video_src_ff  <= '0;
         bytes_left_ff <= '0;
         trailer_ff    <= '0;
      end else begin
         audio_pend_ff <= audio_pend_in;
         video_pend_ff <= video_pend_in;
         epoch_ff      <= epoch_in;
         audio_out_ff  <= audio_out_in;
         audio_src_ff  <= audio_src_in;
         video_out_ff  <= video_out_in;
         video_src_ff  <= video_src_in;
         bytes_left_ff <= bytes_left_in;
         trailer_ff    <= trailer_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/flvtm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FLV tag muxer job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module flvtm_queue
   import flvtm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire flvtm_job_type push_job,
   output logic               q_full,
   output logic               q_valid,
   output flvtm_job_type      q_head,
   input  wire logic          pop
);

   flvtm_job_type         entry_ff [QDEPTH];
   logic [QPTR_W-1:0]     wptr_ff, wptr_in;
   logic [QPTR_W-1:0]     rptr_ff, rptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   assign q_full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ----- design/flvtm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FLV tag muxer back end
// Expands the job at the queue head into stream bytes, one beat per cycle while the receiver accepts.
// ----------------------------------------------------------------------------
module flvtm_back
   import flvtm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire flvtm_job_type q_head,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output flvtm_rsp_type      rsp_payload
);

   localparam logic [7:0] SIGNATURE [FILE_BODY_LEN] = '{
      8'h46, 8'h4c, 8'h56, 8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h09
   };

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   flvtm_rsp_type    rsp_payload_ff, rsp_payload_in;

   logic [IDX_W-1:0] body_len;
   logic [IDX_W-1:0] total_len;
   logic [IDX_W-1:0] trl_idx;
   logic [31:0]      trl_word;
   logic [7:0]       cur_byte;
   logic             is_last;
   logic             emit;

   always_comb begin
      unique case (q_head.op)
         OP_FILE: body_len = IDX_W'(FILE_BODY_LEN);
         OP_TAG:  body_len = IDX_W'(TAG_BODY_LEN);
         OP_DATA: body_len = IDX_W'(DATA_BODY_LEN);
         default: body_len = IDX_W'(DATA_BODY_LEN);
      endcase
      total_len = body_len + (q_head.trailer_en ? IDX_W'(TRAILER_LEN) : '0);
      trl_idx   = idx_ff - body_len;
      trl_word  = {{(32 - TRAILER_W){1'b0}}, q_head.trailer};
      is_last   = (idx_ff == total_len - 1'b1);

      if (idx_ff < body_len) begin
         unique case (q_head.op)
            OP_FILE: cur_byte = SIGNATURE[idx_ff];
            OP_TAG: begin
               case (idx_ff)
                  4'd0:    cur_byte = q_head.type_code;
                  4'd1:    cur_byte = q_head.size[23:16];
                  4'd2:    cur_byte = q_head.size[15:8];
                  4'd3:    cur_byte = q_head.size[7:0];
                  4'd4:    cur_byte = q_head.stamp[23:16];
                  4'd5:    cur_byte = q_head.stamp[15:8];
                  4'd6:    cur_byte = q_head.stamp[7:0];
                  4'd7:    cur_byte = q_head.stamp[31:24];
                  default: cur_byte = 8'h00;
               endcase
            end
            OP_DATA: cur_byte = q_head.data;
            default: cur_byte = q_head.data;
         endcase
      end else begin
         case (trl_idx[1:0])
            2'd0:    cur_byte = trl_word[31:24];
            2'd1:    cur_byte = trl_word[23:16];
            2'd2:    cur_byte = trl_word[15:8];
            default: cur_byte = trl_word[7:0];
         endcase
      end
   end

   always_comb begin
      emit           = q_valid && (!rsp_valid_ff || rsp_ready);
      pop            = emit && is_last;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         idx_in                  = is_last ? '0 : idx_ff + 1'b1;
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_byte = cur_byte;
         rsp_payload_in.last     = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

// ----- design/flv_tag_muxer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FLV tag muxer core
// Turns file-start, tag-start and payload items into an FLV byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one item per beat: a file start, a tag start for
//   audio, video or script, or one payload byte. The rsp channel gives one
//   stream byte per beat, with last set on the final byte that an item causes.
//   A file start yields 13 bytes, a tag start 11 bytes (15 for an empty tag),
//   a payload byte 1 byte (5 for the final byte of a tag, with the trailer).
//   Items that yield nothing are absorbed without effect on the output.
//   An item is registered in the job queue, and its bytes in the back end's
//   output register. Throughput is one output byte per cycle while the
//   receiver accepts, set by the back end that expands each queued job;
//   single-byte items thus sustain one item per cycle; a header item does not.
//   A two-entry job queue sits between front and back; when the receiver
//   stalls, the queue fills and req_ready drops until a job drains.
//   Reset clears the timestamp state and the queue; no tag is open after it.
// ----------------------------------------------------------------------------
module flv_tag_muxer_core
   import flvtm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire flvtm_req_type req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output flvtm_rsp_type      rsp_payload
);

   logic          push;
   flvtm_job_type push_job;
   logic          q_full;
   logic          q_valid;
   flvtm_job_type q_head;
   logic          pop;

   flvtm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   flvtm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .pop      (pop)
   );

   flvtm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- design/flvtm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FLV tag muxer port checker
// Checks what the core's ports show over time.
// ----------------------------------------------------------------------------
module flvtm_checker
   import flvtm_pkg::*;
(
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_valid,
   input wire logic          req_ready,
   input wire flvtm_req_type req_payload,
   input wire logic          rsp_valid,
   input wire logic          rsp_ready,
   input wire flvtm_rsp_type rsp_payload
);

   // A waiting request beat keeps its item.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("req beat changed while waiting");

   // A stalled beat keeps its byte.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // The bytes of one item leave without gaps.
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=> rsp_valid)
      else $error("gap inside the bytes of one item");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready right after reset");

endmodule

bind flv_tag_muxer_core flvtm_checker u_flvtm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

// ----- tb/sv/flv_tag_muxer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLV tag muxer core testbench
// Drives file-start, tag-start and payload beats into the core and checks
// every output byte and its last flag against an in-bench stream predictor.
// A directed part covers file headers, each tag kind, empty and abandoned
// tags, timestamp rebasing and wrap, and the items that must be dropped. A
// random part then streams tags, some cut short, with random content mixed with
// noise. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module flv_tag_muxer_core_tb;
   import flvtm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 210;
   localparam int REPORT_LIMIT = 10;

   localparam logic [1:0] ACT_NONE  = 2'd3;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [7:0]  TYPE_AUDIO    = 8'd8;
   localparam logic [7:0]  TYPE_VIDEO    = 8'd9;
   localparam logic [7:0]  TYPE_SCRIPT   = 8'd18;
   localparam logic [31:0] TAG_HEADER_SZ = 32'd11;
   localparam logic [71:0] FLV_SIGNATURE = 72'h46_4C_56_01_05_00_00_00_09;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   flvtm_req_type req_payload;
   logic          rsp_valid;
   logic          rsp_ready;
   flvtm_rsp_type rsp_payload;

   flv_tag_muxer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   bit          audio_first_pend;
   bit          video_first_pend;
   logic [31:0] epoch_ms;
   logic [31:0] audio_ms;
   logic [31:0] audio_src_ms;
   logic [31:0] video_ms;
   logic [31:0] video_src_ms;
   logic [23:0] bytes_remaining;
   logic [31:0] size_trailer;

   logic [7:0]    stream_bytes[$];
   flvtm_rsp_type expected_bytes[$];

   int          cycle_count;
   int          mismatches;
   int          beats_checked;
   int          items_sent;
   int          stream_items;
   int          files_started;
   int          tags_started;
   bit          req_gap_mode;
   bit          rsp_pressure;
   int          rsp_hold;
   logic [31:0] media_ms;

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached with %0d bytes outstanding", CYCLE_LIMIT,
                  expected_bytes.size());
         $display("flv_tag_muxer_core regression: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready = 1'b0;
         rsp_hold--;
      end else if (rsp_pressure && $urandom_range(0, 99) < 25) begin
         rsp_ready = 1'b0;
         rsp_hold = pick_gap() - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      flvtm_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("unexpected beat: byte %02h last %0b", rsp_payload.out_byte,
                        rsp_payload.last);
            end
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_payload.out_byte !== want.out_byte || rsp_payload.last !== want.last) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("mismatch at beat %0d: expected byte %02h last %0b, got %02h last %0b",
                           beats_checked, want.out_byte, want.last, rsp_payload.out_byte,
                           rsp_payload.last);
               end
               mismatches++;
            end
         end
         beats_checked++;
      end
   end

   task automatic clear_stream_state();
      audio_first_pend = 1'b1;
      video_first_pend = 1'b1;
      epoch_ms = '0;
      audio_ms = '0;
      audio_src_ms = '0;
      video_ms = '0;
      video_src_ms = '0;
      bytes_remaining = '0;
      size_trailer = '0;
   endtask

   task automatic push_word(input logic [31:0] w);
      int idx;
      for (idx = 3; idx >= 0; idx--) begin
         stream_bytes.push_back(w[idx*8 +: 8]);
      end
   endtask

   task automatic predict_flv_bytes(input flvtm_req_type item);
      logic [31:0]   src;
      logic [31:0]   stamp;
      logic [7:0]    tag_type;
      bit            known_kind;
      flvtm_rsp_type beat;
      int            idx;
      src = item.source_time;
      stamp = '0;
      tag_type = '0;
      known_kind = 1'b1;
      stream_bytes.delete();
      case (item.action)
         ACT_FILE: begin
            clear_stream_state();
            files_started++;
            for (idx = 8; idx >= 0; idx--) begin
               stream_bytes.push_back(FLV_SIGNATURE[idx*8 +: 8]);
            end
            push_word(size_trailer);
         end
         ACT_TAG: begin
            case (item.stream_kind)
               KIND_AUDIO: begin
                  tag_type = TYPE_AUDIO;
                  if (audio_first_pend) begin
                     audio_first_pend = 1'b0;
                     if (video_first_pend) begin
                        audio_ms = '0;
                        epoch_ms = src;
                     end else begin
                        audio_ms = src - epoch_ms;
                     end
                  end else begin
                     audio_ms = audio_ms + (src - audio_src_ms);
                  end
                  audio_src_ms = src;
                  stamp = audio_ms;
               end
               KIND_VIDEO: begin
                  tag_type = TYPE_VIDEO;
                  if (video_first_pend) begin
                     video_first_pend = 1'b0;
                     if (audio_first_pend) begin
                        video_ms = '0;
                        epoch_ms = src;
                     end else begin
                        video_ms = src - epoch_ms;
                     end
                  end else begin
                     video_ms = video_ms + (src - video_src_ms);
                  end
                  video_src_ms = src;
                  stamp = video_ms;
               end
               KIND_SCRIPT: begin
                  tag_type = TYPE_SCRIPT;
                  stamp = src;
               end
               default: begin
                  known_kind = 1'b0;
               end
            endcase
            if (known_kind) begin
               tags_started++;
               stream_bytes.push_back(tag_type);
               stream_bytes.push_back(item.payload_size[23:16]);
               stream_bytes.push_back(item.payload_size[15:8]);
               stream_bytes.push_back(item.payload_size[7:0]);
               stream_bytes.push_back(stamp[23:16]);
               stream_bytes.push_back(stamp[15:8]);
               stream_bytes.push_back(stamp[7:0]);
               stream_bytes.push_back(stamp[31:24]);
               stream_bytes.push_back(8'h00);
               stream_bytes.push_back(8'h00);
               stream_bytes.push_back(8'h00);
               size_trailer = {8'h00, item.payload_size} + TAG_HEADER_SZ;
               bytes_remaining = item.payload_size;
               if (item.payload_size == '0) begin
                  push_word(size_trailer);
               end
            end
         end
         ACT_DATA: begin
            if (bytes_remaining != '0) begin
               stream_bytes.push_back(item.data_byte);
               bytes_remaining = bytes_remaining - 24'd1;
               if (bytes_remaining == '0) begin
                  push_word(size_trailer);
               end
            end
         end
         default: begin
         end
      endcase
      for (idx = 0; idx < stream_bytes.size(); idx++) begin
         beat.out_byte = stream_bytes[idx];
         beat.last = (idx == stream_bytes.size() - 1);
         expected_bytes.push_back(beat);
      end
      if (stream_bytes.size() > 0) begin
         stream_items++;
      end
   endtask

   function automatic flvtm_req_type make_req(input logic [1:0] act, input logic [1:0] kind,
                                              input logic [23:0] size, input logic [31:0] ts,
                                              input logic [7:0] data);
      flvtm_req_type item;
      item.action = act;
      item.stream_kind = kind;
      item.payload_size = size;
      item.source_time = ts;
      item.data_byte = data;
      return item;
   endfunction

   function automatic flvtm_req_type random_req(input logic [1:0] act);
      return make_req(act, 2'($urandom()), 24'($urandom()), $urandom(), 8'($urandom()));
   endfunction

   // The item is committed once valid rises, so its bytes are predicted then.
   task automatic send_item(input flvtm_req_type item);
      int gap;
      gap = 0;
      if (req_gap_mode && $urandom_range(0, 99) < 35) begin
         gap = pick_gap();
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = item;
      req_valid = 1'b1;
      predict_flv_bytes(item);
      items_sent++;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic drain_stream();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_bytes.size() > 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic test_file_start();
      send_item(random_req(ACT_FILE));
      drain_stream();
   endtask

   task automatic test_rebase_and_wrap();
      send_item(make_req(ACT_TAG, KIND_VIDEO, 24'd0, 32'h0000_1000, 8'h00));
      send_item(make_req(ACT_TAG, KIND_AUDIO, 24'd1, 32'h0000_0800, 8'h00));
      send_item(make_req(ACT_DATA, KIND_AUDIO, 24'd0, 32'd0, 8'h00));
      send_item(make_req(ACT_TAG, KIND_VIDEO, 24'd2, 32'hFFFF_FFFF, 8'h00));
      send_item(make_req(ACT_DATA, KIND_NONE, 24'hFFFFFF, 32'hFFFF_FFFF, 8'hFF));
      send_item(make_req(ACT_DATA, KIND_VIDEO, 24'd7, 32'd3, 8'h5A));
      send_item(make_req(ACT_TAG, KIND_AUDIO, 24'd0, 32'h0000_0005, 8'h00));
      drain_stream();
   endtask

   task automatic test_script_and_abandon();
      send_item(make_req(ACT_TAG, KIND_SCRIPT, 24'hFFFFFF, 32'hDEAD_BEEF, 8'h00));
      send_item(make_req(ACT_DATA, KIND_SCRIPT, 24'd0, 32'd0, 8'hA5));
      send_item(make_req(ACT_TAG, KIND_AUDIO, 24'd1, 32'h8000_0000, 8'h00));
      send_item(make_req(ACT_DATA, KIND_AUDIO, 24'd0, 32'd0, 8'h3C));
      drain_stream();
   endtask

   task automatic test_dropped_items();
      send_item(make_req(ACT_DATA, KIND_AUDIO, 24'd5, 32'd9, 8'h11));
      send_item(make_req(ACT_TAG, KIND_NONE, 24'd4, 32'd1234, 8'h00));
      send_item(random_req(ACT_NONE));
      drain_stream();
   endtask

   task automatic test_file_restart();
      send_item(make_req(ACT_TAG, KIND_AUDIO, 24'd3, 32'd100, 8'h00));
      send_item(make_req(ACT_DATA, KIND_AUDIO, 24'd0, 32'd0, 8'h77));
      send_item(random_req(ACT_FILE));
      send_item(make_req(ACT_TAG, KIND_AUDIO, 24'd0, 32'd50, 8'h00));
      drain_stream();
   endtask

   task automatic test_random_stream();
      int            target;
      int            r;
      int            body;
      int            idx;
      flvtm_req_type item;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         req_gap_mode = ($urandom_range(0, 3) != 0);
         rsp_pressure = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 5) begin
            send_item(random_req(ACT_FILE));
         end else if (r < 15) begin
            case ($urandom_range(0, 2))
               0: send_item(random_req(ACT_NONE));
               1: begin
                  item = random_req(ACT_TAG);
                  item.stream_kind = KIND_NONE;
                  send_item(item);
               end
               default: send_item(random_req(ACT_DATA));
            endcase
         end else begin
            item = random_req(ACT_TAG);
            item.stream_kind = 2'($urandom_range(0, 2));
            r = $urandom_range(0, 99);
            if (r < 70) begin
               item.payload_size = 24'($urandom_range(0, 6));
            end else if (r < 90) begin
               item.payload_size = 24'($urandom_range(7, 40));
            end
            if (item.stream_kind != KIND_SCRIPT) begin
               if ($urandom_range(0, 99) < 85) begin
                  media_ms = media_ms + $urandom_range(0, 200);
               end else begin
                  media_ms = $urandom();
               end
               item.source_time = media_ms;
            end
            body = int'(item.payload_size);
            if (item.payload_size > 24'd40) begin
               body = $urandom_range(0, 8);
            end else if ($urandom_range(0, 99) < 15) begin
               body = $urandom_range(0, body);
            end
            send_item(item);
            for (idx = 0; idx < body; idx++) begin
               send_item(random_req(ACT_DATA));
            end
         end
      end
      req_gap_mode = 1'b1;
      rsp_pressure = 1'b1;
      drain_stream();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      rsp_hold = 0;
      req_gap_mode = 1'b1;
      rsp_pressure = 1'b1;
      media_ms = $urandom();
      cycle_count = 0;
      mismatches = 0;
      beats_checked = 0;
      items_sent = 0;
      stream_items = 0;
      files_started = 0;
      tags_started = 0;
      clear_stream_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_file_start();
      test_rebase_and_wrap();
      test_script_and_abandon();
      test_dropped_items();
      test_file_restart();
      test_random_stream();

      mismatches += expected_bytes.size();
      $display("Sent %0d items, %0d of which produced output; %0d file starts, %0d tag starts.",
               items_sent, stream_items, files_started, tags_started);
      $display("Checked %0d stream bytes with %0d mismatches.", beats_checked, mismatches);
      if (mismatches == 0) begin
         $display("flv_tag_muxer_core regression: pass");
      end else begin
         $display("flv_tag_muxer_core regression: fail");
      end
      $finish;
   end

endmodule
